@@ sv/btlv_pkg.sv @@
// Shared types and constants for the BER-TLV stream parser.
`default_nettype none

package btlv_pkg;

    localparam int MAX_TAG_BYTES_DEF    = 4;
    localparam int MAX_LENGTH_BYTES_DEF = 4;

    // Counter width for tag and length byte counts (counts reach four; the width holds up to seven).
    localparam int CNT_W = 3;

    localparam logic [7:0] TAG_MULTI_MASK = 8'h1F;
    localparam logic [7:0] LEN_LONG_MIN   = 8'h81;
    localparam logic [7:0] LEN_LONG_MAX   = 8'h84;

    localparam logic [1:0] ROLE_TAG    = 2'd0;
    localparam logic [1:0] ROLE_LENGTH = 2'd1;
    localparam logic [1:0] ROLE_VALUE  = 2'd2;
    localparam logic [1:0] ROLE_REJECT = 2'd3;

    typedef enum logic [4:0] {
        PH_TAG_FIRST = 5'b00001,
        PH_TAG_MORE  = 5'b00010,
        PH_LEN_FIRST = 5'b00100,
        PH_LEN_MORE  = 5'b01000,
        PH_VALUE     = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       resync;
    } byte_in_t;

    typedef struct packed {
        logic [1:0]  byte_role;
        logic [31:0] tag_value;
        logic [31:0] length_value;
        logic [7:0]  value_byte;
        logic        header_done;
        logic        item_end;
        logic        constructed;
        logic [1:0]  tag_class;
    } result_t;

    typedef struct packed {
        phase_t             phase;
        logic [31:0]        tag_accum;
        logic [CNT_W-1:0]   tag_cnt;
        logic [2:0]         first_hi;   // bits 7:5 of the first tag byte
        logic [31:0]        len_accum;
        logic [CNT_W-1:0]   len_left;
        logic [31:0]        val_left;
    } parse_state_t;

endpackage

`default_nettype wire

@@ sv/btlv_stream_if.sv @@
// Valid/ready stream channel carrying one payload word.
`default_nettype none

interface btlv_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/ber_tlv_stream_parser_core.sv @@
// Top level of the BER-TLV stream parser: input stage, decode, result register.
//
// Usage:
//   stream  (sink)   one word per encoded byte: data_byte and resync. A word with
//                    resync set is taken as the first byte of a new tag and any
//                    partial item is dropped without an item end.
//   result  (source) one word per accepted byte: role, tag so far, length,
//                    value byte, header done, item end, constructed and class.
//   Path: an accepted byte passes through one input register, then one result
//   register, before it shows on result with valid high.
//   Throughput: one byte per clock while result.ready is high; the running parse state is updated by a
//   single pass of decode logic each time the input stage hands a byte on.
//   Stall: when result.ready is low the result register holds, the input
//   register holds behind it and stream.ready drops only once both are full.
//   Reset: rst_n low clears both valid flags and puts the parser in the state
//   that expects a first tag byte with tag, length and counters cleared.
`default_nettype none

module ber_tlv_stream_parser_core
    import btlv_pkg::*;
#(
    parameter int MAX_TAG_BYTES    = MAX_TAG_BYTES_DEF,
    parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    btlv_stream_if.sink   stream,
    btlv_stream_if.source result
);

    logic         in_valid_reg;
    byte_in_t     in_word_reg;
    logic         out_valid_reg;
    result_t      out_word_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      res_next;
    logic         advance;

    // The input stage moves on when the result register is empty or drained.
    assign advance      = !out_valid_reg || result.ready;
    assign stream.ready = !in_valid_reg || advance;

    btlv_decode #(
        .MAX_TAG_BYTES    (MAX_TAG_BYTES),
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_decode (
        .cur  (state_reg),
        .item (in_word_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // Input register: capture a word whenever there is room.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (stream.ready)
            in_valid_reg <= stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
            in_word_reg <= stream.payload;
    end

    // Parse state: advance only when a byte leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase     <= PH_TAG_FIRST;
            state_reg.tag_accum <= '0;
            state_reg.tag_cnt   <= '0;
            state_reg.first_hi  <= '0;
            state_reg.len_accum <= '0;
            state_reg.len_left  <= '0;
            state_reg.val_left  <= '0;
        end
        else if (in_valid_reg && advance)
            state_reg <= state_next;
    end

    // Result register: hold while the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_word_reg <= res_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_word_reg;

endmodule

`default_nettype wire

@@ sv/btlv_decode.sv @@
// Next-state and result logic for one byte of the TLV stream.
`default_nettype none

module btlv_decode
    import btlv_pkg::*;
#(
    parameter int MAX_TAG_BYTES    = MAX_TAG_BYTES_DEF,
    parameter int MAX_LENGTH_BYTES = MAX_LENGTH_BYTES_DEF
) (
    input  parse_state_t cur,
    input  byte_in_t     item,
    output parse_state_t nxt,
    output result_t      res
);

    localparam logic [CNT_W-1:0] TAG_LIMIT = CNT_W'(MAX_TAG_BYTES);
    localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(MAX_LENGTH_BYTES);

    logic [7:0]       b;
    phase_t           ph;
    logic [CNT_W-1:0] tag_cnt_inc;
    logic [CNT_W-1:0] len_left_dec;
    logic [31:0]      len_shift;
    logic [31:0]      val_dec;
    logic             long_ok;

    assign b            = item.data_byte;
    assign ph           = item.resync ? PH_TAG_FIRST : cur.phase;
    assign tag_cnt_inc  = cur.tag_cnt + CNT_W'(1);
    assign len_left_dec = cur.len_left - CNT_W'(1);
    assign len_shift    = {cur.len_accum[23:0], b};
    assign val_dec      = cur.val_left - 32'd1;
    assign long_ok      = (b >= LEN_LONG_MIN) && (b <= LEN_LONG_MAX)
                          && ({1'b0, b[3:0]} <= {{(5-CNT_W){1'b0}}, LEN_LIMIT});

    always_comb
    begin
        nxt                  = cur;
        res.byte_role        = ROLE_TAG;
        res.value_byte       = 8'd0;
        res.header_done      = 1'b0;
        res.item_end         = 1'b0;

        case (ph)
            PH_TAG_MORE:
            begin
                nxt.tag_accum = {cur.tag_accum[23:0], b};
                nxt.tag_cnt   = tag_cnt_inc;
                if (b[7] && (tag_cnt_inc < TAG_LIMIT))
                    nxt.phase = PH_TAG_MORE;
                else
                    nxt.phase = PH_LEN_FIRST;
            end
            PH_LEN_FIRST:
            begin
                if (!b[7])
                begin
                    res.byte_role   = ROLE_LENGTH;
                    res.header_done = 1'b1;
                    nxt.len_accum   = {24'd0, b};
                    if (b == 8'd0)
                    begin
                        res.item_end = 1'b1;
                        nxt.phase    = PH_TAG_FIRST;
                    end
                    else
                    begin
                        nxt.val_left = {24'd0, b};
                        nxt.phase    = PH_VALUE;
                    end
                end
                else if (long_ok)
                begin
                    res.byte_role = ROLE_LENGTH;
                    nxt.len_accum = 32'd0;
                    nxt.len_left  = CNT_W'(b[3:0]);
                    nxt.phase     = PH_LEN_MORE;
                end
                else
                begin
                    res.byte_role = ROLE_REJECT;
                    nxt.len_accum = 32'd0;
                    nxt.len_left  = '0;
                    nxt.phase     = PH_TAG_FIRST;
                end
            end
            PH_LEN_MORE:
            begin
                res.byte_role = ROLE_LENGTH;
                nxt.len_accum = len_shift;
                nxt.len_left  = len_left_dec;
                if (len_left_dec == '0)
                begin
                    res.header_done = 1'b1;
                    if (len_shift == 32'd0)
                    begin
                        res.item_end = 1'b1;
                        nxt.phase    = PH_TAG_FIRST;
                    end
                    else
                    begin
                        nxt.val_left = len_shift;
                        nxt.phase    = PH_VALUE;
                    end
                end
            end
            PH_VALUE:
            begin
                res.byte_role  = ROLE_VALUE;
                res.value_byte = b;
                nxt.val_left   = val_dec;
                if (val_dec == 32'd0)
                begin
                    res.item_end = 1'b1;
                    nxt.phase    = PH_TAG_FIRST;
                end
            end
            default:
            begin
                // first tag byte: restart the item
                nxt.tag_accum = {24'd0, b};
                nxt.tag_cnt   = CNT_W'(1);
                nxt.first_hi  = b[7:5];
                nxt.len_accum = 32'd0;
                nxt.len_left  = '0;
                nxt.val_left  = 32'd0;
                if (((b & TAG_MULTI_MASK) == TAG_MULTI_MASK) && (CNT_W'(1) < TAG_LIMIT))
                    nxt.phase = PH_TAG_MORE;
                else
                    nxt.phase = PH_LEN_FIRST;
            end
        endcase

        res.tag_value    = nxt.tag_accum;
        res.length_value = nxt.len_accum;
        res.constructed  = nxt.first_hi[0];
        res.tag_class    = nxt.first_hi[2:1];
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_ber_tlv_stream_parser_core.sv @@
// Self-checking testbench for the BER-TLV stream parser core.
`timescale 1ns / 1ps

module tb_ber_tlv_stream_parser_core;
    import btlv_pkg::*;

    logic clk;
    logic rst_n;

    btlv_stream_if #(.payload_t(byte_in_t)) byte_ch ();
    btlv_stream_if #(.payload_t(result_t))  res_ch ();

    ber_tlv_stream_parser_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (byte_ch.sink),
        .result (res_ch.source)
    );

    // Parser state as this side sees it; it follows every accepted word.
    phase_t      parse_phase = PH_TAG_FIRST;
    logic [31:0] tag_acc     = '0;
    logic [2:0]  tag_cnt     = '0;
    logic [31:0] len_acc     = '0;
    logic [2:0]  len_left    = '0;
    logic [31:0] val_left    = '0;

    // Decoded words still owed by the block, oldest first.
    result_t     pending_results[$];

    int unsigned mismatches  = 0;
    int unsigned words_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned stall_run   = 0;
    logic        stall_level = 1'b0;
    logic        force_resync = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Decode one byte: advance the running parse state and return the
    // word the block should give for it.
    function automatic result_t parse_byte(input byte_in_t w);
        result_t     r;
        logic [7:0]  b;
        logic [7:0]  first;
        phase_t      ph;
        logic        finish;
        r      = '0;
        b      = w.data_byte;
        finish = 1'b0;
        // Resync takes the byte as a first tag byte, whatever the phase.
        ph = w.resync ? PH_TAG_FIRST : parse_phase;
        case (ph)
            PH_TAG_FIRST:
            begin
                r.byte_role = ROLE_TAG;
                tag_acc     = {24'h0, b};
                tag_cnt     = 3'd1;
                len_acc     = '0;
                len_left    = '0;
                val_left    = '0;
                if ((b & TAG_MULTI_MASK) == TAG_MULTI_MASK && 1 < MAX_TAG_BYTES_DEF)
                    parse_phase = PH_TAG_MORE;
                else
                    parse_phase = PH_LEN_FIRST;
            end
            PH_TAG_MORE:
            begin
                r.byte_role = ROLE_TAG;
                tag_acc     = {tag_acc[23:0], b};
                tag_cnt     = tag_cnt + 3'd1;
                if (b[7] && tag_cnt < MAX_TAG_BYTES_DEF)
                    parse_phase = PH_TAG_MORE;
                else
                    parse_phase = PH_LEN_FIRST;
            end
            PH_LEN_FIRST:
            begin
                if (b <= 8'd127)
                begin
                    r.byte_role = ROLE_LENGTH;
                    len_acc     = {24'h0, b};
                    finish      = 1'b1;
                end
                else if (b >= LEN_LONG_MIN && b <= LEN_LONG_MAX
                         && b[3:0] <= MAX_LENGTH_BYTES_DEF)
                begin
                    r.byte_role = ROLE_LENGTH;
                    len_acc     = '0;
                    len_left    = b[2:0];
                    parse_phase = PH_LEN_MORE;
                end
                else
                begin
                    // Indefinite or oversized length form: drop the header.
                    r.byte_role = ROLE_REJECT;
                    len_acc     = '0;
                    len_left    = '0;
                    parse_phase = PH_TAG_FIRST;
                end
            end
            PH_LEN_MORE:
            begin
                r.byte_role = ROLE_LENGTH;
                len_acc     = {len_acc[23:0], b};
                len_left    = len_left - 3'd1;
                if (len_left == 3'd0)
                    finish = 1'b1;
            end
            default:
            begin
                r.byte_role  = ROLE_VALUE;
                r.value_byte = b;
                val_left     = val_left - 32'd1;
                if (val_left == 32'd0)
                begin
                    r.item_end  = 1'b1;
                    parse_phase = PH_TAG_FIRST;
                end
            end
        endcase
        if (finish)
        begin
            r.header_done = 1'b1;
            // A zero-length item ends on its last length byte.
            if (len_acc == 32'd0)
            begin
                r.item_end  = 1'b1;
                parse_phase = PH_TAG_FIRST;
            end
            else
            begin
                val_left    = len_acc;
                parse_phase = PH_VALUE;
            end
        end
        if (tag_cnt == 3'd0 || tag_cnt > 3'd4)
            first = 8'h00;
        else
            first = 8'(tag_acc >> ((tag_cnt - 3'd1) * 8));
        r.tag_value    = tag_acc;
        r.length_value = len_acc;
        r.constructed  = first[5];
        r.tag_class    = first[7:6];
        return r;
    endfunction

    // Send one word. The sender runs in bursts; when a burst runs out, drop
    // valid for a random gap, then start a new burst. Hold the word until
    // the block takes it, then queue what it should answer.
    task automatic send_byte(input logic [7:0] data, input logic rs);
        byte_in_t    w;
        int unsigned gap;
        w.data_byte = data;
        w.resync    = rs;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        byte_ch.valid   <= 1'b1;
        byte_ch.payload <= w;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        pending_results.push_back(parse_byte(w));
        words_sent++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            $error("result word with nothing outstanding: %0h", got);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            check_field("byte_role",    32'(want.byte_role),    32'(got.byte_role));
            check_field("tag_value",    want.tag_value,         got.tag_value);
            check_field("length_value", want.length_value,      got.length_value);
            check_field("value_byte",   32'(want.value_byte),   32'(got.value_byte));
            check_field("header_done",  32'(want.header_done),  32'(got.header_done));
            check_field("item_end",     32'(want.item_end),     32'(got.item_end));
            check_field("constructed",  32'(want.constructed),  32'(got.constructed));
            check_field("tag_class",    32'(want.tag_class),    32'(got.tag_class));
        end
    endtask

    // Result side: check every word taken at this edge, then pick the ready
    // level for the next cycle. Longer ready runs mix at random with shorter stalls.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                check_result(res_ch.payload);
            if (stall_run == 0)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    stall_level = 1'b0;
                    stall_run   = $urandom_range(1, 6);
                end
                else
                begin
                    stall_level = 1'b1;
                    stall_run   = $urandom_range(1, 25);
                end
            end
            stall_run--;
            res_ch.ready <= stall_level;
        end
    end

    // Short-form lengths: a zero-length item ends on its length byte, and a
    // private constructed tag with one value byte.
    task automatic test_short_form();
        send_byte(8'h04, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hE3, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hAA, 1'b0);
    endtask

    // Multi-byte tags with long-form lengths: a two-byte tag with a
    // four-byte length, and a tag capped at four bytes although its last
    // byte still has bit 7 set, followed by a one-byte long form of zero.
    task automatic test_multi_byte_tag();
        send_byte(8'h5F, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'h84, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hEE, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h81, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Indefinite and oversized length forms, each followed by a fresh tag.
    task automatic test_rejected_length();
        send_byte(8'h41, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // Resync drops a partial item: first in the value of the longest length,
    // then in the middle of a multi-byte tag.
    task automatic test_resync();
        send_byte(8'h62, 1'b0);
        send_byte(8'h84, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h1F, 1'b1);
        send_byte(8'h81, 1'b0);
        send_byte(8'h20, 1'b1);
        send_byte(8'h00, 1'b0);
    endtask

    // One random piece of stream: mostly well-formed items with random
    // tags, lengths and payloads; some raw noise, rejected length forms and
    // items with huge lengths that a later resync cuts short.
    task automatic send_random_item();
        int unsigned kind;
        int unsigned tag_len;
        int unsigned n_len;
        int unsigned min_len;
        int unsigned i;
        logic [31:0] value_len;
        logic [7:0]  b;
        logic        rs;
        logic        cut;
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            return;
        end
        rs = force_resync || ($urandom_range(0, 9) == 0);
        force_resync = 1'b0;
        if (kind < 13)
        begin
            b = 8'($urandom);
            b[4:0] = 5'h0E;
            send_byte(b, rs);
            if ($urandom_range(0, 1) == 0)
                send_byte(8'h80, 1'b0);
            else
                send_byte(8'($urandom_range(8'h85, 8'hFF)), 1'b0);
            return;
        end
        cut = (kind >= 95);
        // Tag: mostly one byte, the rest chained up to four bytes.
        tag_len = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : 1;
        b = 8'($urandom);
        if (tag_len > 1)
            b[4:0] = 5'h1F;
        else if (b[4:0] == 5'h1F)
            b[0] = 1'b0;
        send_byte(b, rs);
        for (i = 2; i <= tag_len; i++)
        begin
            b = 8'($urandom);
            if (i < tag_len)
                b[7] = 1'b1;
            else if (tag_len < 4)
                b[7] = 1'b0;
            send_byte(b, 1'b0);
        end
        // Length: keep payloads short except on rare items.
        if (cut)
            value_len = $urandom;
        else if ($urandom_range(0, 49) == 0)
            value_len = $urandom_range(128, 260);
        else if ($urandom_range(0, 19) == 0)
            value_len = $urandom_range(0, 127);
        else
            value_len = $urandom_range(0, 12);
        if (cut || value_len > 127 || $urandom_range(0, 2) == 0)
        begin
            if (value_len[31:24] != 0)
                min_len = 4;
            else if (value_len[23:16] != 0)
                min_len = 3;
            else if (value_len[15:8] != 0)
                min_len = 2;
            else
                min_len = 1;
            n_len = $urandom_range(min_len, 4);
            send_byte(8'h80 | 8'(n_len), 1'b0);
            for (i = n_len; i > 0; i--)
                send_byte(8'(value_len >> ((i - 1) * 8)), 1'b0);
        end
        else
            send_byte(value_len[7:0], 1'b0);
        if (cut)
        begin
            // Leave the item open; the next header starts with a resync.
            repeat ($urandom_range(0, 5))
                send_byte(8'($urandom), 1'b0);
            force_resync = 1'b1;
            return;
        end
        for (i = 0; i < value_len; i++)
            send_byte(8'($urandom), 1'b0);
    endtask

    task automatic test_random_stream();
        int unsigned start_count;
        start_count = words_sent;
        while (words_sent - start_count < 850)
            send_random_item();
    endtask

    // Main sequence: reset once, run the directed cases, then the random
    // stream, then drain what is still owed and report.
    initial
    begin
        byte_ch.valid   <= 1'b0;
        byte_ch.payload <= '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_form();
        test_multi_byte_tag();
        test_rejected_length();
        test_resync();
        test_random_stream();
        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Wait on after that to catch any stray result words.
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_ber_tlv_stream_parser_core passed");
        else
            $display("tb_ber_tlv_stream_parser_core failed");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("tb_ber_tlv_stream_parser_core failed");
        $finish;
    end

endmodule

@@ ber_tlv_stream_parser_core.f @@
sv/btlv_pkg.sv
sv/btlv_stream_if.sv
sv/btlv_decode.sv
sv/ber_tlv_stream_parser_core.sv
tb/sv/tb_ber_tlv_stream_parser_core.sv
